// ===== rtl/core/chs_pkg.sv =====
// ----------------------------------------------------------------------------
// chs_pkg: compass heading smoother shared definitions
// Types, constants and the arctangent table used by the core and its CORDIC.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int CHS_CORDIC_STEPS    = 16;
  localparam int CHS_ANGLE_FRAC_BITS = 8;

  localparam int TAB_LEN  = 24;
  localparam int XY_W     = 24;
  localparam int DIFF_W   = 14;
  localparam int ANG_W    = 18;
  localparam int HEAD_W   = 17;
  localparam int DEG_W    = 9;
  localparam int CFG_W    = 17;
  localparam int SAMPLE_W = 13;

  localparam logic [HEAD_W-1:0] FULL_TURN = HEAD_W'(92160);
  localparam logic [DEG_W-1:0]  DEADBAND  = DEG_W'(3);

  localparam logic [1:0] REG_DECLINATION = 2'd0;
  localparam logic [1:0] REG_OFFSET_X    = 2'd1;
  localparam logic [1:0] REG_OFFSET_Y    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROT,
    S_WRAP,
    S_MAP,
    S_EMIT
  } chs_state_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] y;
  } chs_cordic_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ANG_W-1:0] angle;
  } chs_cordic_stat_t;

  // arctan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_raw(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/chs_cordic.sv =====
// ----------------------------------------------------------------------------
// chs_cordic: iterative vectoring CORDIC
// One shared micro-rotation unit, one step per cycle; returns atan2 in
// 1/256 degree.
// ----------------------------------------------------------------------------
module chs_cordic
  import chs_pkg::*;
#(
  parameter int STEPS = CHS_CORDIC_STEPS,
  parameter int FRAC  = CHS_ANGLE_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  chs_cordic_req_t  req,
  output chs_cordic_stat_t stat
);

  localparam int NSTEP = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;
  localparam int ZW    = FRAC + 11;
  localparam int CW    = ZW + 9;
  localparam int SH    = 16 - FRAC;
  localparam int SHR   = (FRAC > 8) ? FRAC - 8 : 0;
  localparam int SHL   = (FRAC > 8) ? 0 : 8 - FRAC;
  localparam int RND   = (FRAC > 8) ? (1 << SHR) / 2 : 0;
  localparam logic [4:0]           LAST = 5'(NSTEP - 1);
  localparam logic signed [ZW-1:0] Z180 = ZW'(180 * (1 << FRAC));
  localparam logic [22:0]          TRND = 23'(1 << (SH - 1));

  logic signed [XY_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0]   z_r, z_nxt;
  logic [4:0]             i_r, i_nxt;
  logic                   busy_r, busy_nxt, done_r, done_nxt, zero_r, zero_nxt;

  logic signed [21:0]     xl22, yl22;
  logic signed [XY_W-1:0] xl, yl, xs, ys;
  logic [22:0]            tab_sum;
  logic signed [ZW-1:0]   ent;
  logic signed [CW-1:0]   z_ext, z_conv;

  assign xl22    = {req.x, 8'h00};
  assign yl22    = {req.y, 8'h00};
  assign xl      = {{(XY_W-22){xl22[21]}}, xl22};
  assign yl      = {{(XY_W-22){yl22[21]}}, yl22};
  assign xs      = x_r >>> i_r;
  assign ys      = y_r >>> i_r;
  assign tab_sum = ({1'b0, atan_raw(i_r)} + TRND) >> SH;
  assign ent     = tab_sum[ZW-1:0];

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    if (req.start) begin
      zero_nxt = (req.x == '0) && (req.y == '0);
      busy_nxt = 1'b1;
      i_nxt    = '0;
      if (req.x < 0) begin
        x_nxt = -xl;
        y_nxt = -yl;
        z_nxt = Z180;
      end else begin
        x_nxt = xl;
        y_nxt = yl;
        z_nxt = '0;
      end
    end else if (busy_r) begin
      if (y_r >= 0) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + ent;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - ent;
      end
      i_nxt = i_r + 5'd1;
      if (i_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      i_r    <= i_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    zero_r <= zero_nxt;
  end

  assign z_ext  = {{9{z_r[ZW-1]}}, z_r};
  assign z_conv = ((z_ext + CW'(RND)) >>> SHR) <<< SHL;

  assign stat.done  = done_r;
  assign stat.angle = zero_r ? '0 : z_conv[ANG_W-1:0];

endmodule

// ===== rtl/core/compass_heading_smoother_core.sv =====
// ----------------------------------------------------------------------------
// compass_heading_smoother_core: magnetometer compass heading with deadband
// Offset removal, CORDIC atan2, declination and wrap, two-segment degree
// correction and a +/-3 degree deadband on the whole-degree output.
// ----------------------------------------------------------------------------
// One word is processed at a time: in_ready is high only while the core is
// idle, and the next word can be accepted only once the current one has
// gone through every step below (CORDIC steps capped at 24). The pace is
// set by the single micro-rotation unit: the offset-corrected operands are
// loaded, the unit then does one CORDIC step per cycle, and declination
// add, wrap, correction map and output load follow, each in its own
// register. A finished result waits in the output register, so the next
// word is accepted while it is still unread; a result that finds that
// register still full holds the core until out_ready frees it.
// ----------------------------------------------------------------------------
module compass_heading_smoother_core
  import chs_pkg::*;
#(
  parameter int CORDIC_STEPS    = CHS_CORDIC_STEPS,
  parameter int ANGLE_FRAC_BITS = CHS_ANGLE_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_mag_x,
  input  logic signed [SAMPLE_W-1:0] in_mag_y,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [HEAD_W-1:0]          out_heading_raw,
  output logic [DEG_W-1:0]           out_heading_smoothed
);

  localparam logic [23:0] MAP_K = 24'((179 * (64'd1 << 24) + 238) / 239);

  chs_state_t state_r, state_nxt;

  logic signed [CFG_W-1:0]    decl_r;
  logic signed [SAMPLE_W-1:0] offx_r, offy_r;
  logic signed [HEAD_W+1:0]   hsum_r;
  logic [HEAD_W-1:0]          h_r;
  logic [DEG_W-1:0]           corr_r, last_r;
  logic                       out_valid_r;
  logic [HEAD_W-1:0]          out_raw_r;
  logic [DEG_W-1:0]           out_sm_r;

  logic                       accept, hsum_we, h_we, corr_we, out_load;
  chs_cordic_req_t            creq;
  chs_cordic_stat_t           cstat;
  logic signed [HEAD_W+1:0]   hsum_calc, hwrap;
  logic [DEG_W-1:0]           deg, corr_calc, seg_hi, smooth;
  logic [6:0]                 seg_t;
  logic [32:0]                prod;
  logic [DEG_W:0]             c10, p10;

  assign accept   = in_valid && in_ready;
  assign creq.start = accept;
  assign creq.x   = DIFF_W'(in_mag_x) - DIFF_W'(offx_r);
  assign creq.y   = DIFF_W'(in_mag_y) - DIFF_W'(offy_r);

  chs_cordic #(
    .STEPS (CORDIC_STEPS),
    .FRAC  (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .stat  (cstat)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_ROT;
      S_ROT:   if (cstat.done) state_nxt = S_WRAP;
      S_WRAP:  state_nxt = S_MAP;
      S_MAP:   state_nxt = S_EMIT;
      S_EMIT:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    hsum_we  = 1'b0;
    h_we     = 1'b0;
    corr_we  = 1'b0;
    out_load = 1'b0;
    case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_ROT:   hsum_we  = cstat.done;
      S_WRAP:  h_we     = 1'b1;
      S_MAP:   corr_we  = 1'b1;
      S_EMIT:  out_load = !out_valid_r || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  assign hsum_calc = (HEAD_W+2)'(cstat.angle) + (HEAD_W+2)'(decl_r);

  always_comb begin
    if (hsum_r < 0) begin
      hwrap = hsum_r + $signed({2'b00, FULL_TURN});
    end else if (hsum_r > $signed({2'b00, FULL_TURN})) begin
      hwrap = hsum_r - $signed({2'b00, FULL_TURN});
    end else begin
      hwrap = hsum_r;
    end
  end

  assign deg    = h_r[HEAD_W-1:8];
  assign prod   = deg * MAP_K;
  assign seg_t  = 7'(deg - DEG_W'(240));
  assign seg_hi = DEG_W'(seg_t) + DEG_W'(seg_t >> 1) + DEG_W'(180);

  always_comb begin
    if (deg == '0) begin
      corr_calc = '0;
    end else if (deg < DEG_W'(240)) begin
      corr_calc = prod[32:24];
    end else begin
      corr_calc = seg_hi;
    end
  end

  assign c10    = {1'b0, corr_r};
  assign p10    = {1'b0, last_r};
  assign smooth = ((c10 < p10 + {1'b0, DEADBAND}) && (c10 + {1'b0, DEADBAND} > p10)) ?
                  last_r : corr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      decl_r      <= CFG_W'(1135);
      offx_r      <= '0;
      offy_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_DECLINATION: decl_r <= cfg_wdata;
          REG_OFFSET_X:    offx_r <= cfg_wdata[SAMPLE_W-1:0];
          REG_OFFSET_Y:    offy_r <= cfg_wdata[SAMPLE_W-1:0];
          default:         decl_r <= decl_r;
        endcase
      end
      if (out_load) begin
        last_r      <= smooth;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (hsum_we) hsum_r <= hsum_calc;
    if (h_we) h_r <= hwrap[HEAD_W-1:0];
    if (corr_we) corr_r <= corr_calc;
    if (out_load) begin
      out_raw_r <= h_r;
      out_sm_r  <= smooth;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_heading_raw      = out_raw_r;
  assign out_heading_smoothed = out_sm_r;

`ifndef ASSERT_OFF
  a_raw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_heading_raw <= FULL_TURN)
    else $error("heading_raw beyond full turn");

  a_sm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_heading_smoothed <= DEG_W'(360))
    else $error("heading_smoothed beyond 360");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("ready right after accepting a word");

  a_done_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
    cstat.done |-> state_r == S_ROT)
    else $error("CORDIC finished outside rotation phase");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: compass heading smoother core testbench
// Drives magnetometer words through the valid/ready input channel, predicts
// each raw and smoothed heading in software (offset removal, CORDIC atan2,
// declination, wrap, degree map, deadband) and checks every output word in
// order. Registers are rewritten between phases while the core is drained.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import chs_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int TURN_Q8 = 360 * 256;
  localparam int HOLD_DEG = 3;

  typedef struct packed {
    logic [HEAD_W-1:0] raw;
    logic [DEG_W-1:0]  smoothed;
  } heading_t;

  class heading_predictor;
    int decl;
    int ofs_x;
    int ofs_y;
    int prev_deg;
    int checked;
    int holds;
    int errors;
    heading_t expected_headings[$];

    function new();
      decl = 1135;
      ofs_x = 0;
      ofs_y = 0;
      prev_deg = 0;
      checked = 0;
      holds = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
      logic signed [16:0] d17;
      logic signed [12:0] d13;
      d17 = data;
      d13 = data[12:0];
      case (idx)
        REG_DECLINATION: decl = int'(d17);
        REG_OFFSET_X: ofs_x = int'(d13);
        REG_OFFSET_Y: ofs_y = int'(d13);
        default: ;
      endcase
    endfunction

    function int frac_bits();
      int f;
      f = CHS_ANGLE_FRAC_BITS;
      if (f < 0) f = 0;
      if (f > 16) f = 16;
      return f;
    endfunction

    function int step_angle(int i);
      int unsigned t;
      int sh;
      sh = 16 - frac_bits();
      case (i)
        0: t = 2949120;
        1: t = 1740967;
        2: t = 919879;
        3: t = 466945;
        4: t = 234379;
        5: t = 117304;
        6: t = 58666;
        7: t = 29335;
        8: t = 14668;
        9: t = 7334;
        10: t = 3667;
        11: t = 1833;
        12: t = 917;
        13: t = 458;
        14: t = 229;
        15: t = 115;
        16: t = 57;
        17: t = 29;
        18: t = 14;
        19: t = 7;
        20: t = 4;
        21: t = 2;
        22: t = 1;
        default: t = 0;
      endcase
      if (sh == 0) return int'(t);
      return int'((t + (32'd1 << (sh - 1))) >> sh);
    endfunction

    // atan2(y, x) in 1/256 degree
    function int atan2_deg256(int x, int y);
      int f, z, steps, xs, ys, xa, ya, i;
      f = frac_bits();
      z = 0;
      if (x == 0 && y == 0) return 0;
      xa = x * 256;
      ya = y * 256;
      if (xa < 0) begin
        xa = -xa;
        ya = -ya;
        z = 180 * (1 << f);
      end
      steps = (CHS_CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CHS_CORDIC_STEPS;
      for (i = 0; i < steps; i++) begin
        xs = xa >>> i;
        ys = ya >>> i;
        if (ya >= 0) begin
          xa = xa + ys;
          ya = ya - xs;
          z = z + step_angle(i);
        end else begin
          xa = xa - ys;
          ya = ya + xs;
          z = z - step_angle(i);
        end
      end
      if (f > 8) return (z + (1 << (f - 9))) >>> (f - 8);
      return z * (1 << (8 - f));
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] mx,
                              logic signed [SAMPLE_W-1:0] my);
      int x, y, h, d, c, s;
      heading_t e;
      x = int'(mx) - ofs_x;
      y = int'(my) - ofs_y;
      h = atan2_deg256(x, y) + decl;
      while (h < 0) h += TURN_Q8;
      while (h > TURN_Q8) h -= TURN_Q8;
      d = h / 256;
      if (d < 1) c = 0;
      else if (d < 240) c = d * 179 / 239;
      else c = (d - 240) * 180 / 120 + 180;
      s = c;
      if (s < prev_deg + HOLD_DEG && s > prev_deg - HOLD_DEG) begin
        if (s != prev_deg) holds++;
        s = prev_deg;
      end
      prev_deg = s & 'h1FF;
      e.raw = h[HEAD_W-1:0];
      e.smoothed = s[DEG_W-1:0];
      expected_headings.push_back(e);
    endfunction

    function void check_heading(logic [HEAD_W-1:0] raw, logic [DEG_W-1:0] sm);
      heading_t e;
      if (expected_headings.size() == 0) begin
        $error("unexpected word: heading_raw=%0d heading_smoothed=%0d", raw, sm);
        errors++;
        return;
      end
      e = expected_headings.pop_front();
      checked++;
      if (raw !== e.raw) begin
        $error("heading_raw: expected %0d, actual %0d", e.raw, raw);
        errors++;
      end
      if (sm !== e.smoothed) begin
        $error("heading_smoothed: expected %0d, actual %0d", e.smoothed, sm);
        errors++;
      end
    endfunction

    function int pending();
      return expected_headings.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [1:0]                 cfg_index = REG_DECLINATION;
  logic [CFG_W-1:0]           cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_mag_x = '0;
  logic signed [SAMPLE_W-1:0] in_mag_y = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [HEAD_W-1:0]          out_heading_raw;
  logic [DEG_W-1:0]           out_heading_smoothed;

  heading_predictor pred;
  bit src_idle_en = 1'b1;
  bit snk_stall_en = 1'b1;
  int n_cfg = 0;
  int wx, wy;

  compass_heading_smoother_core dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      pred.check_heading(out_heading_raw, out_heading_smoothed);
    if (rst_n && in_valid && in_ready)
      pred.note_sample(in_mag_x, in_mag_y);
  end

  initial begin
    forever begin
      @(negedge clk);
      if (snk_stall_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic int clip13(int v);
    if (v > 4095) return 4095;
    if (v < -4096) return -4096;
    return v;
  endfunction

  // call at a falling edge; returns at a falling edge with valid still high
  task automatic send_sample(input int x, input int y);
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mag_x <= SAMPLE_W'(x);
    in_mag_y <= SAMPLE_W'(y);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pred.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    pred.write_reg(idx, data);
    n_cfg++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic zero_vector_at(input int decl);
    settle();
    write_reg(REG_DECLINATION, CFG_W'(decl));
    send_sample(pred.ofs_x, pred.ofs_y);
  endtask

  task automatic random_config();
    int d, o;
    case ($urandom_range(0, 7))
      0: d = -65536;
      1: d = 65535;
      2: d = -46080;
      3: d = 46080;
      4, 5: d = int'($urandom_range(0, 92160)) - 46080;
      default: d = int'($urandom & 32'h1FFFF);
    endcase
    write_reg(REG_DECLINATION, CFG_W'(d));
    o = int'($urandom_range(0, 400)) - 200;
    if ($urandom_range(0, 2) == 0) write_reg(REG_OFFSET_X, CFG_W'($urandom));
    else write_reg(REG_OFFSET_X, {4'($urandom), 13'(o)});
    o = int'($urandom_range(0, 400)) - 200;
    if ($urandom_range(0, 2) == 0) write_reg(REG_OFFSET_Y, CFG_W'($urandom));
    else write_reg(REG_OFFSET_Y, {4'($urandom), 13'(o)});
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_W'($urandom));
  endtask

  initial begin
    int ph, k, sel, x, y;
    pred = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_sample(0, 0);
    send_sample(4095, 4095);
    send_sample(-4096, -4096);
    send_sample(4095, -4096);
    send_sample(-4096, 4095);
    send_sample(4095, 0);
    send_sample(-4096, 0);
    send_sample(0, 4095);
    send_sample(0, -4096);
    send_sample(-1, 0);
    send_sample(4095, 1);
    send_sample(1, -1);

    settle();
    write_reg(REG_UNUSED, 17'h1ABCD);
    write_reg(REG_DECLINATION, CFG_W'(0));
    write_reg(REG_OFFSET_X, CFG_W'(-4096));
    write_reg(REG_OFFSET_Y, CFG_W'(4095));
    send_sample(4095, -4096);
    send_sample(-4096, 4095);
    send_sample(0, 0);

    settle();
    write_reg(REG_DECLINATION, CFG_W'(-65536));
    write_reg(REG_OFFSET_X, CFG_W'(4095));
    write_reg(REG_OFFSET_Y, CFG_W'(-4096));
    send_sample(-4096, 4095);
    send_sample(4095, -4096);

    settle();
    write_reg(REG_OFFSET_X, CFG_W'(0));
    write_reg(REG_OFFSET_Y, CFG_W'(0));
    zero_vector_at(0);
    zero_vector_at(255);
    zero_vector_at(256);
    zero_vector_at(-1);
    zero_vector_at(61439);
    zero_vector_at(61440);
    zero_vector_at(65535);
    settle();
    write_reg(REG_DECLINATION, CFG_W'(TURN_Q8 - pred.atan2_deg256(-1, 0)));
    send_sample(-1, 0);

    for (ph = 0; ph < 8; ph++) begin
      settle();
      random_config();
      if (ph == 7) begin
        src_idle_en = 1'b0;
        snk_stall_en = 1'b0;
      end
      wx = clip13(pred.ofs_x + ($urandom_range(0, 1) ? 3000 : -3000));
      wy = clip13(pred.ofs_y + int'($urandom_range(0, 2000)) - 1000);
      for (k = 0; k < 80; k++) begin
        sel = $urandom_range(0, 19);
        if (sel < 10) begin
          wx = clip13(wx + int'($urandom_range(0, 80)) - 40);
          wy = clip13(wy + int'($urandom_range(0, 80)) - 40);
          x = wx;
          y = wy;
        end else if (sel < 17) begin
          x = int'(SAMPLE_W'($urandom));
          x = (x > 4095) ? x - 8192 : x;
          y = int'(SAMPLE_W'($urandom));
          y = (y > 4095) ? y - 8192 : y;
        end else begin
          x = clip13(pred.ofs_x + int'($urandom_range(0, 6)) - 3);
          y = clip13(pred.ofs_y + int'($urandom_range(0, 6)) - 3);
        end
        send_sample(x, y);
      end
    end

    in_valid <= 1'b0;
    while (pred.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Checked %0d heading words across %0d register writes;", pred.checked, n_cfg);
    $display("the deadband held the previous degree %0d times.", pred.holds);
    if (pred.errors == 0 && pred.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/chs_pkg.sv
rtl/core/chs_cordic.sv
rtl/core/compass_heading_smoother_core.sv
tb/tb_top.sv
